// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the SOR cell update core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DSOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DSOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/dsor_pkg.sv -----
// Shared widths, types and constants of the SOR cell update core.
package dsor_pkg;

	// field widths
	localparam int POT_W      = 18;
	localparam int EPS_W      = 12;
	localparam int RELAX_W    = 15;
	localparam int RELAX_FRAC = 14;
	localparam logic [RELAX_W-1:0] RELAX_ONE = RELAX_W'(1) << RELAX_FRAC;

	// weighted sums and divider
	localparam int PROD_W     = POT_W + EPS_W;
	localparam int NUM_W      = PROD_W + 1;
	localparam int DEN_W      = EPS_W + 1;
	localparam int GUARD_W    = 16;
	localparam int DVD_W      = NUM_W + GUARD_W;
	localparam int QUO_W      = 36;
	localparam int DIV_BPS    = 4;
	localparam int DIV_STAGES = QUO_W / DIV_BPS;
	localparam int REM_W      = DEN_W;

	// blend
	localparam int SQ_W        = QUO_W + 1;
	localparam int OLD_SHIFT   = GUARD_W + 1;
	localparam int DIFF_W      = SQ_W + 2;
	localparam int PROD2_W     = DIFF_W + RELAX_W + 1;
	localparam int TOT_W       = PROD2_W + 1;
	localparam int FINAL_SHIFT = OLD_SHIFT + RELAX_FRAC;
	localparam int RND_W       = TOT_W - FINAL_SHIFT;

	typedef logic signed [POT_W-1:0] pot_t;
	typedef logic [EPS_W-1:0] eps_t;

	localparam pot_t POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
	localparam pot_t POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

	// per-cell data that bypasses the arithmetic
	typedef struct packed {
		pot_t centre;
		logic hold;
		logic zflag;
	} side_t;

	// one axis of the divider: partial remainder, dividend/quotient shift word, divisor, sign
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] work;
		logic [DEN_W-1:0] den;
		logic             neg;
	} lane_t;

	typedef struct packed {
		lane_t hor;
		lane_t ver;
		side_t side;
	} div_item_t;

endpackage

// ----- rtl/core/dielectric_sor_cell_update_core.sv -----
// Top level of the dielectric SOR cell update core.
// Usage:
//   Input channel (in_valid/in_ready) takes one cell request per cycle: four
//   neighbor potentials, the center potential, four neighbor permittivities
//   and the conductor/interior flags. Output channel (out_valid/out_ready)
//   returns new_pot and zero_divisor, one result per request, in order.
//   Config channel (cfg_valid/cfg_ready) writes relax_coeff (Q1.14); it is
//   always ready and should only be written while no request is in flight.
// Timing:
//   16 register stages: 2 front stages, 9 divider stages (4 quotient bits
//   each, both axes in parallel) and 5 blend stages. Throughput is one cell
//   per cycle while out_ready stays high.
// Reset:
//   arst_n clears all stage valid bits and loads relax_coeff with 1.0.
// Stall:
//   When out_ready is low the stages fill up; bubbles are squeezed out and
//   in_ready drops only once every stage holds a request. Nothing is lost
//   or repeated.
`include "assert_macros.svh"

module dielectric_sor_cell_update_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dsor_pkg::RELAX_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dsor_pkg::pot_t               left_pot,
	input  dsor_pkg::pot_t               top_pot,
	input  dsor_pkg::pot_t               right_pot,
	input  dsor_pkg::pot_t               bottom_pot,
	input  dsor_pkg::pot_t               centre_pot,
	input  dsor_pkg::eps_t               left_eps,
	input  dsor_pkg::eps_t               top_eps,
	input  dsor_pkg::eps_t               right_eps,
	input  dsor_pkg::eps_t               bottom_eps,
	input  logic                         is_conductor,
	input  logic                         is_interior,
	output logic                         out_valid,
	input  logic                         out_ready,
	output dsor_pkg::pot_t               new_pot,
	output logic                         zero_divisor
);

	logic [dsor_pkg::RELAX_W-1:0] relax_q;
	logic                         fr_valid, fr_ready;
	dsor_pkg::div_item_t          fr_item;
	logic                         dv_valid, dv_ready;
	dsor_pkg::div_item_t          dv_item;

	// relaxation factor register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) relax_q <= dsor_pkg::RELAX_ONE;
		else if (cfg_valid) relax_q <= cfg_data;
	end

	dsor_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_pot     (left_pot),
		.top_pot      (top_pot),
		.right_pot    (right_pot),
		.bottom_pot   (bottom_pot),
		.centre_pot   (centre_pot),
		.left_eps     (left_eps),
		.top_eps      (top_eps),
		.right_eps    (right_eps),
		.bottom_eps   (bottom_eps),
		.is_conductor (is_conductor),
		.is_interior  (is_interior),
		.out_valid    (fr_valid),
		.out_ready    (fr_ready),
		.out_item     (fr_item)
	);

	dsor_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_item  (dv_item)
	);

	dsor_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.relax_coeff  (relax_q),
		.in_valid     (dv_valid),
		.in_ready     (dv_ready),
		.in_item      (dv_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_pot      (new_pot),
		.zero_divisor (zero_divisor)
	);

	// input backpressure only when every stage is full and the output is stalled
	`DSOR_ASSERT_IMP(a_stall_full, clk, arst_n, !in_ready, out_valid && !out_ready)
	// a zero divisor always forces the held center value
	`DSOR_ASSERT_IMP(a_zero_holds, clk, arst_n, dv_valid && dv_item.side.zflag, dv_item.side.hold)
	// a config request lands in the factor register
	`DSOR_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_valid, relax_q == $past(cfg_data))

endmodule

// ----- rtl/core/dsor_front.sv -----
// Front end: permittivity-weighted sums, divisors and divider setup.
module dsor_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsor_pkg::pot_t      left_pot,
	input  dsor_pkg::pot_t      top_pot,
	input  dsor_pkg::pot_t      right_pot,
	input  dsor_pkg::pot_t      bottom_pot,
	input  dsor_pkg::pot_t      centre_pot,
	input  dsor_pkg::eps_t      left_eps,
	input  dsor_pkg::eps_t      top_eps,
	input  dsor_pkg::eps_t      right_eps,
	input  dsor_pkg::eps_t      bottom_eps,
	input  logic                is_conductor,
	input  logic                is_interior,
	output logic                out_valid,
	input  logic                out_ready,
	output dsor_pkg::div_item_t out_item
);

	logic signed [dsor_pkg::PROD_W-1:0] prod_l_s1, prod_r_s1, prod_t_s1, prod_b_s1;
	logic [dsor_pkg::DEN_W-1:0] den_h_s1, den_v_s1;
	dsor_pkg::pot_t centre_s1;
	logic calc_s1;
	logic v_s1, v_s2;
	logic ready_s1, ready_s2;
	dsor_pkg::div_item_t item_s2;
	dsor_pkg::div_item_t item_d;
	logic zero_d;

	// potential times permittivity, both extended to the product width
	function automatic logic signed [dsor_pkg::PROD_W-1:0] wprod(dsor_pkg::pot_t p,
			dsor_pkg::eps_t e);
		logic signed [dsor_pkg::PROD_W-1:0] px;
		logic signed [dsor_pkg::PROD_W-1:0] ex;
		px = dsor_pkg::PROD_W'(p);
		ex = dsor_pkg::PROD_W'($signed({1'b0, e}));
		return px * ex;
	endfunction

	// sign/magnitude split and dividend with the half-divisor rounding term
	function automatic dsor_pkg::lane_t lane_init(logic signed [dsor_pkg::PROD_W-1:0] pa,
			logic signed [dsor_pkg::PROD_W-1:0] pb, logic [dsor_pkg::DEN_W-1:0] den);
		logic signed [dsor_pkg::NUM_W-1:0] num;
		logic [dsor_pkg::NUM_W-1:0] mag;
		logic [dsor_pkg::DVD_W-1:0] dvd;
		dsor_pkg::lane_t l;
		num = dsor_pkg::NUM_W'(pa) + dsor_pkg::NUM_W'(pb);
		mag = num[dsor_pkg::NUM_W-1] ? dsor_pkg::NUM_W'(-num) : dsor_pkg::NUM_W'(num);
		dvd = {mag, dsor_pkg::GUARD_W'(den[dsor_pkg::DEN_W-1:1])};
		// top bits are below the divisor since the quotient fits QUO_W bits
		l.rem  = dsor_pkg::REM_W'(dvd[dsor_pkg::DVD_W-1:dsor_pkg::QUO_W]);
		l.work = dvd[dsor_pkg::QUO_W-1:0];
		l.den  = den;
		l.neg  = num[dsor_pkg::NUM_W-1];
		return l;
	endfunction

	// backpressure chain
	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: products and divisors
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_l_s1 <= wprod(left_pot, left_eps);
			prod_r_s1 <= wprod(right_pot, right_eps);
			prod_t_s1 <= wprod(top_pot, top_eps);
			prod_b_s1 <= wprod(bottom_pot, bottom_eps);
			den_h_s1  <= dsor_pkg::DEN_W'(left_eps) + dsor_pkg::DEN_W'(right_eps);
			den_v_s1  <= dsor_pkg::DEN_W'(top_eps) + dsor_pkg::DEN_W'(bottom_eps);
			centre_s1 <= centre_pot;
			calc_s1   <= !is_conductor && is_interior;
		end
	end

	// stage 2: numerators, special cases
	always_comb begin
		zero_d = (den_h_s1 == '0) || (den_v_s1 == '0);
		item_d.hor = lane_init(prod_l_s1, prod_r_s1, den_h_s1);
		item_d.ver = lane_init(prod_t_s1, prod_b_s1, den_v_s1);
		item_d.side.centre = centre_s1;
		item_d.side.hold   = !calc_s1 || zero_d;
		item_d.side.zflag  = calc_s1 && zero_d;
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) item_s2 <= item_d;
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

// ----- rtl/core/dsor_div.sv -----
// Pipelined restoring divider, both axes side by side, DIV_BPS quotient bits per stage.
module dsor_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsor_pkg::div_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dsor_pkg::div_item_t out_item
);

	localparam int LAST = dsor_pkg::DIV_STAGES - 1;

	logic                vld_s [dsor_pkg::DIV_STAGES];
	logic                rdy   [dsor_pkg::DIV_STAGES];
	dsor_pkg::div_item_t div_s [dsor_pkg::DIV_STAGES];

	// DIV_BPS shift-compare-subtract steps; quotient bits enter work at the bottom
	function automatic dsor_pkg::lane_t div_step(dsor_pkg::lane_t l);
		logic [dsor_pkg::REM_W:0] trial;
		dsor_pkg::lane_t r;
		r = l;
		for (int i = 0; i < dsor_pkg::DIV_BPS; i++) begin
			trial  = {r.rem, r.work[dsor_pkg::QUO_W-1]};
			r.work = {r.work[dsor_pkg::QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, r.den}) begin
				trial     = trial - {1'b0, r.den};
				r.work[0] = 1'b1;
			end
			r.rem = trial[dsor_pkg::REM_W-1:0];
		end
		return r;
	endfunction

	for (genvar k = 0; k < dsor_pkg::DIV_STAGES; k++) begin : g_stage
		dsor_pkg::div_item_t src;
		logic src_v;
		logic nxt_rdy;

		if (k == 0) begin : g_first
			assign src   = in_item;
			assign src_v = in_valid;
		end else begin : g_rest
			assign src   = div_s[k-1];
			assign src_v = vld_s[k-1];
		end

		if (k == LAST) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy[k+1];
		end

		assign rdy[k] = !vld_s[k] || nxt_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (rdy[k]) vld_s[k] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) begin
				div_s[k].hor  <= div_step(src.hor);
				div_s[k].ver  <= div_step(src.ver);
				div_s[k].side <= src.side;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[LAST];
	assign out_item  = div_s[LAST];

endmodule

// ----- rtl/core/dsor_blend.sv -----
// Back end: signed axis means, relaxation blend, rounding and saturation.
module dsor_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dsor_pkg::RELAX_W-1:0] relax_coeff,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dsor_pkg::div_item_t          in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output dsor_pkg::pot_t               new_pot,
	output logic                         zero_divisor
);

	localparam logic [dsor_pkg::TOT_W-1:0] ROUND_HALF =
		dsor_pkg::TOT_W'(1) << (dsor_pkg::FINAL_SHIFT - 1);
	localparam logic [dsor_pkg::RND_W-1:0] POS_LIM =
		dsor_pkg::RND_W'((2 ** (dsor_pkg::POT_W - 1)) - 1);
	localparam logic [dsor_pkg::RND_W-1:0] NEG_LIM =
		dsor_pkg::RND_W'(2 ** (dsor_pkg::POT_W - 1));

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	logic signed [dsor_pkg::SQ_W-1:0]    sq_h_s1, sq_v_s1;
	logic signed [dsor_pkg::DIFF_W-1:0]  diff_s2;
	logic signed [dsor_pkg::PROD2_W-1:0] prod_s3;
	logic signed [dsor_pkg::TOT_W-1:0]   total_s4;
	dsor_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	dsor_pkg::pot_t  pot_s5;
	logic            zflag_s5;

	logic signed [dsor_pkg::SQ_W-1:0]    qh_d, qv_d;
	logic signed [dsor_pkg::DIFF_W-1:0]  old_d;
	logic signed [dsor_pkg::PROD2_W-1:0] relax_x, diff_x;
	logic [dsor_pkg::TOT_W-1:0]          rnd_d;
	logic [dsor_pkg::RND_W-1:0]          mag_d;
	logic                                neg_d;
	dsor_pkg::pot_t                      sat_d;

	// backpressure chain
	assign ready_s5 = !v_s5 || out_ready;
	assign ready_s4 = !v_s4 || ready_s5;
	assign ready_s3 = !v_s3 || ready_s4;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (ready_s4) v_s4 <= v_s3;
			if (ready_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: apply sign to each axis quotient
	assign qh_d = $signed({1'b0, in_item.hor.work});
	assign qv_d = $signed({1'b0, in_item.ver.work});

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sq_h_s1 <= in_item.hor.neg ? -qh_d : qh_d;
			sq_v_s1 <= in_item.ver.neg ? -qv_d : qv_d;
			side_s1 <= in_item.side;
		end
	end

	// stage 2: twice the target (sum of the axis means) minus the scaled old value
	assign old_d = dsor_pkg::DIFF_W'(side_s1.centre) <<< dsor_pkg::OLD_SHIFT;

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			diff_s2 <= dsor_pkg::DIFF_W'(sq_h_s1) + dsor_pkg::DIFF_W'(sq_v_s1) - old_d;
			side_s2 <= side_s1;
		end
	end

	// stage 3: relaxation multiply
	assign relax_x = dsor_pkg::PROD2_W'($signed({1'b0, relax_coeff}));
	assign diff_x  = dsor_pkg::PROD2_W'(diff_s2);

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			prod_s3 <= relax_x * diff_x;
			side_s3 <= side_s2;
		end
	end

	// stage 4: add old value at full scale
	always_ff @(posedge clk) begin
		if (ready_s4 && v_s3) begin
			total_s4 <= dsor_pkg::TOT_W'(prod_s3)
				+ (dsor_pkg::TOT_W'(side_s3.centre) <<< dsor_pkg::FINAL_SHIFT);
			side_s4  <= side_s3;
		end
	end

	// stage 5: round half away from zero, saturate, pick held value
	always_comb begin
		neg_d = total_s4[dsor_pkg::TOT_W-1];
		rnd_d = neg_d ? (ROUND_HALF - dsor_pkg::TOT_W'(total_s4))
			: (dsor_pkg::TOT_W'(total_s4) + ROUND_HALF);
		mag_d = rnd_d[dsor_pkg::TOT_W-1:dsor_pkg::FINAL_SHIFT];
		if (!neg_d) begin
			sat_d = (mag_d > POS_LIM) ? dsor_pkg::POT_MAX : mag_d[dsor_pkg::POT_W-1:0];
		end else begin
			sat_d = (mag_d > NEG_LIM) ? dsor_pkg::POT_MIN : -mag_d[dsor_pkg::POT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && v_s4) begin
			pot_s5   <= side_s4.hold ? side_s4.centre : sat_d;
			zflag_s5 <= side_s4.zflag;
		end
	end

	assign out_valid    = v_s5;
	assign new_pot      = pot_s5;
	assign zero_divisor = zflag_s5;

endmodule

// ----- tb/dielectric_sor_cell_update_core_tb.sv -----
// Self-checking testbench for the dielectric SOR cell update core.
`timescale 1ns / 1ps

module dielectric_sor_cell_update_core_tb;
	import dsor_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_REPORTS = 10;
	localparam logic [EPS_W-1:0] EPS_MAX = {EPS_W{1'b1}};
	localparam logic [RELAX_W-1:0] RELAX_MAX = {RELAX_W{1'b1}};
	// axis quotient carries GUARD_W extra bits, old value is scaled to 2u
	localparam longint GUARD_ONE = longint'(1) << GUARD_W;
	localparam longint BLEND_ONE = longint'(1) << (GUARD_W + 1 + RELAX_FRAC);

	typedef struct {
		pot_t left_pot;
		pot_t top_pot;
		pot_t right_pot;
		pot_t bottom_pot;
		pot_t centre_pot;
		eps_t left_eps;
		eps_t top_eps;
		eps_t right_eps;
		eps_t bottom_eps;
		logic is_conductor;
		logic is_interior;
	} cell_req_t;

	typedef struct {
		pot_t new_pot;
		logic zero_divisor;
	} cell_res_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RELAX_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pot_t left_pot = '0;
	pot_t top_pot = '0;
	pot_t right_pot = '0;
	pot_t bottom_pot = '0;
	pot_t centre_pot = '0;
	eps_t left_eps = '0;
	eps_t top_eps = '0;
	eps_t right_eps = '0;
	eps_t bottom_eps = '0;
	logic is_conductor = 1'b0;
	logic is_interior = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	pot_t new_pot;
	logic zero_divisor;

	cell_req_t pending_cells[$];
	cell_res_t expected_pots[$];
	cell_req_t offered_cell;
	logic [RELAX_W-1:0] relax_setting = RELAX_ONE;

	int send_gap_max = 9;
	int recv_stall_max = 9;
	int send_wait = 0;
	int recv_wait = 0;
	int long_hold = 0;
	logic req_taken = 1'b0;
	logic res_taken = 1'b0;
	int error_count = 0;
	int result_count = 0;
	longint cycle_count = 0;

	dielectric_sor_cell_update_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_pot     (left_pot),
		.top_pot      (top_pot),
		.right_pot    (right_pot),
		.bottom_pot   (bottom_pot),
		.centre_pot   (centre_pot),
		.left_eps     (left_eps),
		.top_eps      (top_eps),
		.right_eps    (right_eps),
		.bottom_eps   (bottom_eps),
		.is_conductor (is_conductor),
		.is_interior  (is_interior),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_pot      (new_pot),
		.zero_divisor (zero_divisor)
	);

	// divide rounding to nearest, ties away from zero; den is positive
	function automatic longint div_round(input longint num, input longint den);
		longint mag;
		longint quo;
		mag = (num < 0) ? -num : num;
		quo = (mag + den / 2) / den;
		return (num < 0) ? -quo : quo;
	endfunction

	// permittivity-weighted mean of one axis, GUARD_W extra fraction bits
	function automatic longint weighted_mean(input longint pa, input longint ea,
			input longint pb, input longint eb);
		return div_round((ea * pa + eb * pb) * GUARD_ONE, ea + eb);
	endfunction

	function automatic cell_res_t relaxed_potential(input cell_req_t c,
			input logic [RELAX_W-1:0] relax);
		cell_res_t r;
		longint twice_u;
		longint old_scaled;
		longint total;
		longint val;
		r.new_pot = c.centre_pot;
		r.zero_divisor = 1'b0;
		if (!c.is_conductor && c.is_interior) begin
			if (c.left_eps + c.right_eps == 0 || c.top_eps + c.bottom_eps == 0) begin
				r.zero_divisor = 1'b1;
			end else begin
				twice_u = weighted_mean(c.left_pot, c.left_eps, c.right_pot, c.right_eps)
					+ weighted_mean(c.top_pot, c.top_eps, c.bottom_pot, c.bottom_eps);
				old_scaled = longint'(c.centre_pot) * 2 * GUARD_ONE;
				total = old_scaled * longint'(RELAX_ONE)
					+ longint'(relax) * (twice_u - old_scaled);
				val = div_round(total, BLEND_ONE);
				if (val < longint'(POT_MIN)) val = longint'(POT_MIN);
				if (val > longint'(POT_MAX)) val = longint'(POT_MAX);
				r.new_pot = pot_t'(val);
			end
		end
		return r;
	endfunction

	function automatic pot_t random_pot();
		case ($urandom_range(0, 9))
			0: return POT_MAX;
			1: return POT_MIN;
			2: return pot_t'(int'($urandom_range(0, 511)) - 256);
			default: return pot_t'($urandom);
		endcase
	endfunction

	function automatic eps_t random_eps();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return EPS_MAX;
			2: return eps_t'($urandom_range(1, 16));
			default: return eps_t'($urandom);
		endcase
	endfunction

	function automatic cell_req_t random_cell();
		cell_req_t c;
		c.left_pot = random_pot();
		c.top_pot = random_pot();
		c.right_pot = random_pot();
		c.bottom_pot = random_pot();
		c.centre_pot = random_pot();
		c.left_eps = random_eps();
		c.top_eps = random_eps();
		c.right_eps = random_eps();
		c.bottom_eps = random_eps();
		// force a dead axis now and then
		if ($urandom_range(0, 15) == 0) begin
			c.left_eps = '0;
			c.right_eps = '0;
		end
		if ($urandom_range(0, 15) == 0) begin
			c.top_eps = '0;
			c.bottom_eps = '0;
		end
		c.is_conductor = ($urandom_range(0, 9) == 0);
		c.is_interior = ($urandom_range(0, 9) != 0);
		return c;
	endfunction

	task automatic push_cell(input pot_t lp, input pot_t tp, input pot_t rp, input pot_t bp,
			input pot_t cp, input eps_t le, input eps_t te, input eps_t re, input eps_t be,
			input logic cond, input logic inner);
		pending_cells.push_back('{lp, tp, rp, bp, cp, le, te, re, be, cond, inner});
	endtask

	// block until every request went in and every result came back
	task automatic wait_idle();
		@(posedge clk);
		while (pending_cells.size() != 0 || in_valid || expected_pots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_relax(input logic [RELAX_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		relax_setting = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count, input int gap_max, input int stall_max);
		send_gap_max = gap_max;
		recv_stall_max = stall_max;
		repeat (count) pending_cells.push_back(random_cell());
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// accept a request and queue its prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_pots.push_back(relaxed_potential(offered_cell, relax_setting));
			req_taken = 1'b1;
		end
	end

	// request driver: holds a request until accepted, then a random gap
	always @(negedge clk) begin
		if (req_taken) send_wait = $urandom_range(0, send_gap_max);
		if (arst_n && in_valid && !req_taken) begin
			// keep payload steady
		end else if (arst_n && send_wait == 0 && pending_cells.size() != 0) begin
			offered_cell = pending_cells.pop_front();
			in_valid <= 1'b1;
			left_pot <= offered_cell.left_pot;
			top_pot <= offered_cell.top_pot;
			right_pot <= offered_cell.right_pot;
			bottom_pot <= offered_cell.bottom_pot;
			centre_pot <= offered_cell.centre_pot;
			left_eps <= offered_cell.left_eps;
			top_eps <= offered_cell.top_eps;
			right_eps <= offered_cell.right_eps;
			bottom_eps <= offered_cell.bottom_eps;
			is_conductor <= offered_cell.is_conductor;
			is_interior <= offered_cell.is_interior;
		end else begin
			in_valid <= 1'b0;
			if (send_wait > 0) send_wait--;
		end
		req_taken = 1'b0;
	end

	// result receiver: random stall per result, plus an occasional long hold
	always @(negedge clk) begin
		if (res_taken) recv_wait = $urandom_range(0, recv_stall_max);
		res_taken = 1'b0;
		if (long_hold > 0) begin
			long_hold--;
			out_ready <= 1'b0;
		end else if (recv_wait > 0) begin
			recv_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		cell_res_t want;
		if (arst_n && out_valid && out_ready) begin
			res_taken = 1'b1;
			result_count++;
			if (expected_pots.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result #%0d: new_pot %0d zero_divisor %0b",
						result_count, new_pot, zero_divisor);
			end else begin
				want = expected_pots.pop_front();
				if (new_pot !== want.new_pot || zero_divisor !== want.zero_divisor) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("result #%0d: new_pot exp %0d got %0d, zero_divisor exp %0b got %0b",
							result_count, want.new_pot, new_pot, want.zero_divisor,
							zero_divisor);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed cells at the reset relaxation factor of 1.0
		send_gap_max = 9;
		recv_stall_max = 9;
		push_cell('0, '0, '0, '0, '0, 1, 1, 1, 1, 1'b0, 1'b1);
		push_cell(POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MAX,
			EPS_MAX, EPS_MAX, EPS_MAX, EPS_MAX, 1'b0, 1'b1);
		push_cell(POT_MIN, POT_MIN, POT_MIN, POT_MIN, POT_MIN,
			EPS_MAX, EPS_MAX, EPS_MAX, EPS_MAX, 1'b0, 1'b1);
		push_cell(POT_MAX, POT_MIN, POT_MIN, POT_MAX, '0, 1, EPS_MAX, EPS_MAX, 1, 1'b0, 1'b1);
		// conductor and border cells keep the center value
		push_cell(POT_MAX, POT_MAX, POT_MAX, POT_MAX, 1234, 256, 256, 256, 256, 1'b1, 1'b1);
		push_cell(POT_MIN, POT_MIN, POT_MIN, POT_MIN, -777, 256, 256, 256, 256, 1'b0, 1'b0);
		push_cell(POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MIN, 9, 9, 9, 9, 1'b1, 1'b0);
		// conductor/border wins over a dead axis
		push_cell(100, 200, 300, 400, 55, 0, 0, 0, 0, 1'b1, 1'b1);
		push_cell(100, 200, 300, 400, 66, 0, 5, 0, 5, 1'b0, 1'b0);
		// dead horizontal, dead vertical, both dead
		push_cell(100, 200, 300, 400, 500, 0, 5, 0, 7, 1'b0, 1'b1);
		push_cell(100, 200, 300, 400, -500, 3, 0, 4, 0, 1'b0, 1'b1);
		push_cell(100, 200, 300, 400, POT_MAX, 0, 0, 0, 0, 1'b0, 1'b1);
		// one zero permittivity per axis is legal
		push_cell(POT_MAX, POT_MIN, 7, -9, 0, 0, 10, 10, 0, 1'b0, 1'b1);
		// rounding ties in both directions
		push_cell(1, 1, 0, 0, 0, 1, 1, 1, 1, 1'b0, 1'b1);
		push_cell(-1, -1, 0, 0, 0, 1, 1, 1, 1, 1'b0, 1'b1);
		push_cell(1, 0, 0, 0, 0, 1, 1, 1, 1, 1'b0, 1'b1);
		push_cell(1, 1, 0, 0, 0, 1, 1, 2, 1, 1'b0, 1'b1);
		push_cell(-1, 1, 2, -2, 3, 3, 5, 7, 11, 1'b0, 1'b1);
		wait_idle();
		run_random(255, 9, 9);

		write_relax('0);
		run_random(255, 9, 9);

		// maximum over-relaxation drives the result into both rails
		write_relax(RELAX_MAX);
		push_cell(POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MIN, 256, 256, 256, 256, 1'b0, 1'b1);
		push_cell(POT_MIN, POT_MIN, POT_MIN, POT_MIN, POT_MAX, 256, 256, 256, 256, 1'b0, 1'b1);
		push_cell(POT_MAX, POT_MAX, POT_MAX, POT_MAX, '0, EPS_MAX, 1, 1, EPS_MAX, 1'b0, 1'b1);
		push_cell(POT_MIN, POT_MIN, POT_MIN, POT_MIN, '0, 1, EPS_MAX, EPS_MAX, 1, 1'b0, 1'b1);
		run_random(255, 9, 9);

		// back-to-back requests against a long output hold to fill the pipe
		write_relax(1);
		long_hold = 150;
		run_random(255, 0, 0);

		write_relax(RELAX_W'($urandom_range(0, 32767)));
		run_random(255, 9, 9);

		write_relax(RELAX_W'(24576));
		run_random(255, 9, 0);

		write_relax(RELAX_ONE);
		run_random(255, 0, 9);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_pots.size() != 0) error_count++;
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
